/* hw/rtl/srht_pkg.sv */
package srht_pkg;

    localparam int MAX_CIRCLES_DEF    = 16;
    localparam int MAX_RECTS_DEF      = 16;
    localparam int TRIG_FRAC_BITS_DEF = 14;

    localparam int CW = 15;   // coordinate width
    localparam int SW = 14;   // size width
    localparam int RW = 9;    // rotation width
    localparam int R2W = 28;  // squared radius width

    typedef enum logic [1:0] {
        OP_QUERY = 2'd0,
        OP_ADD_CIRCLE = 2'd1,
        OP_ADD_RECT = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_ADDED = 2'd0,
        ST_MERGED = 2'd1,
        ST_ZERO = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    typedef struct packed {
        op_t             op;
        logic            excluded;
        logic [CW-1:0]   x;
        logic [CW-1:0]   y;
        logic [SW-1:0]   a;
        logic [SW-1:0]   b;
        logic [RW-1:0]   rot;
        logic            zero;
    } cmd_t;

    typedef struct packed {
        logic            in_area;
        status_t         status;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_TEST,
        S_WRITE,
        S_DONE
    } state_t;

    // Q1.14-style sine of 0..90 degrees at the given fraction bits, rounded
    function automatic logic [17:0] sin_q(input logic [6:0] d, input int fb);
        real s;
        real pi;
        pi = 3.14159265358979323846;
        s = $sin(pi * real'(d) / 180.0) * real'(64'd1 << fb);
        return 18'($rtoi(s + 0.5));
    endfunction

endpackage

/* hw/rtl/srht_ram.sv */
module srht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [AW-1:0]            raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hw/rtl/srht_front.sv */
module srht_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  srht_pkg::cmd_t    in_cmd,
    output logic              q_valid,
    input  logic              q_ready,
    output srht_pkg::cmd_t    q_cmd
);
    import srht_pkg::*;

    // two-entry queue between front and back
    cmd_t      buf_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg;
    logic       rp_reg;
    cmd_t       cmd_c;
    logic [RW:0] rot_w;
    logic       push;
    logic       pop;

    always_comb
    begin
        cmd_c = in_cmd;
        rot_w = {1'b0, in_cmd.rot};
        if (rot_w >= 10'd360)
        begin
            rot_w = rot_w - 10'd360;
        end
        cmd_c.rot = rot_w[RW-1:0];
        cmd_c.zero = (in_cmd.a == '0) ||
                     ((in_cmd.op == OP_ADD_RECT) && (in_cmd.b == '0));
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd = buf_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= cmd_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

/* hw/rtl/srht_back.sv */
module srht_back #(
    parameter int MAX_CIRCLES = srht_pkg::MAX_CIRCLES_DEF,
    parameter int MAX_RECTS = srht_pkg::MAX_RECTS_DEF,
    parameter int TRIG_FRAC_BITS = srht_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  srht_pkg::cmd_t    q_cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output srht_pkg::res_t    res
);
    import srht_pkg::*;

    localparam int CIW = $clog2(MAX_CIRCLES + 1);
    localparam int RIW = $clog2(MAX_RECTS + 1);
    localparam int IW = (CIW > RIW) ? CIW : RIW;
    localparam int CAW = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
    localparam int RAW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CEW = 2 * CW + R2W;
    localparam int REW = 2 * CW + 2 * SW + RW;
    localparam int FB = TRIG_FRAC_BITS;
    localparam int PW = 17 + 17 + FB + 2;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic [1:0] list_reg, list_next;       // 0 incl circ, 1 incl rect, 2 excl circ, 3 excl rect
    logic [IW-1:0] idx_reg, idx_next;
    logic   hit_reg, hit_next;
    logic   found_reg, found_next;
    logic [IW-1:0] fidx_reg, fidx_next;
    logic [IW-1:0] cnt_reg [4];
    logic [IW-1:0] cnt_sel;
    res_t   res_reg, res_next;
    logic   rv_reg, rv_next;
    logic [1:0] cnt_inc;
    logic   inc_en;

    // entry products
    logic signed [16:0] dx_reg, dy_reg;
    logic signed [17:0] s_reg, c_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic [31:0] dd_reg;

    // memories
    logic c_we [2];
    logic r_we [2];
    logic [CEW-1:0] c_wd;
    logic [REW-1:0] r_wd;
    logic [CEW-1:0] c_rd [2];
    logic [REW-1:0] r_rd [2];
    logic [CAW-1:0] c_wa;
    logic [RAW-1:0] r_wa;

    genvar g;
    generate
        for (g = 0; g < 2; g++)
        begin : g_mem
            srht_ram #(.WIDTH(CEW), .DEPTH(MAX_CIRCLES)) u_cram (
                .clk(clk), .we(c_we[g]), .waddr(c_wa), .wdata(c_wd),
                .raddr(idx_reg[CAW-1:0]), .rdata(c_rd[g]));
            srht_ram #(.WIDTH(REW), .DEPTH(MAX_RECTS)) u_rram (
                .clk(clk), .we(r_we[g]), .waddr(r_wa), .wdata(r_wd),
                .raddr(idx_reg[RAW-1:0]), .rdata(r_rd[g]));
        end
    endgenerate

    // decode read entry
    logic [CEW-1:0] ce;
    logic [REW-1:0] re;
    logic signed [CW-1:0] ex, ey;
    logic [R2W-1:0] er2;
    logic [SW-1:0] ew, eh;
    logic [RW-1:0] erot;
    logic is_rect;
    logic [R2W-1:0] a2;

    assign is_rect = list_reg[0];
    assign ce = c_rd[list_reg[1]];
    assign re = r_rd[list_reg[1]];
    assign ex = is_rect ? re[REW-1 -: CW] : ce[CEW-1 -: CW];
    assign ey = is_rect ? re[REW-1-CW -: CW] : ce[CEW-1-CW -: CW];
    assign er2 = ce[R2W-1:0];
    assign ew = re[2*SW+RW-1 -: SW];
    assign eh = re[SW+RW-1 -: SW];
    assign erot = re[RW-1:0];
    assign a2 = {{(R2W-SW){1'b0}}, cmd_reg.a} * {{(R2W-SW){1'b0}}, cmd_reg.a};
    assign cnt_sel = cnt_reg[list_reg];

    // sine of whole degree from quarter table
    function automatic logic signed [17:0] sin_deg(input logic [RW:0] d);
        logic [17:0] v;
        logic neg;
        logic [RW:0] q;
        v = '0;
        neg = 1'b0;
        q = d;
        if (d <= 10'd90)
        begin
            q = d;
        end
        else if (d <= 10'd180)
        begin
            q = 10'd180 - d;
        end
        else if (d <= 10'd270)
        begin
            q = d - 10'd180;
            neg = 1'b1;
        end
        else
        begin
            q = 10'd360 - d;
            neg = 1'b1;
        end
        v = sin_q(q[6:0], FB);
        return neg ? -$signed(v) : $signed(v);
    endfunction

    logic [RW:0] rot_c;
    assign rot_c = ({1'b0, erot} + 10'd90 >= 10'd360) ?
                   ({1'b0, erot} + 10'd90 - 10'd360) : ({1'b0, erot} + 10'd90);

    // rounding of accumulated products
    logic signed [PW-1:0] xs, ys;
    logic signed [PW-1:0] xr, yr;
    logic in_c, in_r, ent_hit;
    logic [RW-1:0] rot_hold_reg;
    logic [SW-1:0] w_hold_reg, h_hold_reg;
    logic [R2W-1:0] r2_hold_reg;
    logic match;

    assign xs = p1_reg + p2_reg + (PW'(1) <<< (FB - 1));
    assign ys = p3_reg - p4_reg + (PW'(1) <<< (FB - 1));
    assign xr = xs >>> FB;
    assign yr = ys >>> FB;
    assign in_c = (dd_reg <= {{(32-R2W){1'b0}}, r2_hold_reg});
    assign in_r = (rot_hold_reg == '0) ?
        (dx_reg >= 0 && dx_reg < $signed({3'b0, w_hold_reg}) &&
         dy_reg >= 0 && dy_reg < $signed({3'b0, h_hold_reg})) :
        (xr >= 0 && xr < $signed(PW'(w_hold_reg)) &&
         yr >= 0 && yr < $signed(PW'(h_hold_reg)));
    assign ent_hit = is_rect ? in_r : in_c;

    // compare for adds (on read data, in CALC)
    assign match = is_rect ?
        (ex == cmd_reg.x && ey == cmd_reg.y && ew == cmd_reg.a &&
         eh == cmd_reg.b && erot == cmd_reg.rot) :
        (ex == cmd_reg.x && ey == cmd_reg.y);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CALC)
        begin
            dx_reg <= 17'($signed(cmd_reg.x)) - 17'(ex);
            dy_reg <= 17'($signed(cmd_reg.y)) - 17'(ey);
            s_reg <= sin_deg({1'b0, erot});
            c_reg <= sin_deg(rot_c);
            rot_hold_reg <= erot;
            w_hold_reg <= ew;
            h_hold_reg <= eh;
            r2_hold_reg <= er2;
        end
    end

    // product stage: one registered multiply set per entry
    logic [2:0] sub_reg, sub_next;
    always_ff @(posedge clk)
    begin
        if (state_reg == S_TEST && sub_reg == 3'd0)
        begin
            p1_reg <= PW'(dx_reg) * PW'(c_reg);
            p2_reg <= PW'(dy_reg) * PW'(s_reg);
            p3_reg <= PW'(dy_reg) * PW'(c_reg);
            p4_reg <= PW'(dx_reg) * PW'(s_reg);
            dd_reg <= 32'(34'(dx_reg) * 34'(dx_reg) + 34'(dy_reg) * 34'(dy_reg));
        end
    end

    assign c_wa = found_reg ? fidx_reg[CAW-1:0] : cnt_sel[CAW-1:0];
    assign r_wa = found_reg ? fidx_reg[RAW-1:0] : cnt_sel[RAW-1:0];
    assign c_wd = {cmd_reg.x, cmd_reg.y,
                   (found_reg && er2 > a2) ? er2 : a2};
    assign r_wd = {cmd_reg.x, cmd_reg.y, cmd_reg.a, cmd_reg.b, cmd_reg.rot};

    logic scan_end;
    assign scan_end = (cnt_sel <= idx_reg);

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        list_next = list_reg;
        idx_next = idx_reg;
        hit_next = hit_reg;
        found_next = found_reg;
        fidx_next = fidx_reg;
        res_next = res_reg;
        rv_next = rv_reg;
        sub_next = sub_reg;
        q_ready = 1'b0;
        c_we[0] = 1'b0;
        c_we[1] = 1'b0;
        r_we[0] = 1'b0;
        r_we[1] = 1'b0;
        inc_en = 1'b0;
        cnt_inc = list_reg;
        if (rv_reg && res_ready)
        begin
            rv_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (!rv_reg || res_ready)
                begin
                    q_ready = 1'b1;
                    if (q_valid)
                    begin
                        cmd_next = q_cmd;
                        idx_next = '0;
                        hit_next = 1'b0;
                        found_next = 1'b0;
                        res_next = '{in_area: 1'b0, status: ST_ADDED};
                        if (q_cmd.op == OP_QUERY)
                        begin
                            list_next = 2'd0;
                            state_next = S_SCAN;
                        end
                        else if (q_cmd.op == OP_NONE)
                        begin
                            state_next = S_DONE;
                        end
                        else if (q_cmd.zero)
                        begin
                            res_next.status = ST_ZERO;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            list_next = {q_cmd.excluded, q_cmd.op == OP_ADD_RECT};
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                // read issued at idx_reg; check bounds
                if (scan_end || (cmd_reg.op == OP_QUERY &&
                    ((list_reg[1] == 1'b0 && hit_reg) || (list_reg[1] && !hit_reg))))
                begin
                    if (cmd_reg.op == OP_QUERY)
                    begin
                        if (list_reg == 2'd3)
                        begin
                            res_next.in_area = hit_reg;
                            state_next = S_DONE;
                        end
                        else if (list_reg == 2'd1 && !hit_reg)
                        begin
                            res_next.in_area = 1'b0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            list_next = list_reg + 2'd1;
                            idx_next = '0;
                        end
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
                else
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (cmd_reg.op == OP_QUERY)
                begin
                    sub_next = '0;
                    state_next = S_TEST;
                end
                else if (match)
                begin
                    found_next = 1'b1;
                    fidx_next = idx_reg;
                    state_next = S_WRITE;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                    state_next = S_SCAN;
                end
            end
            S_TEST:
            begin
                if (sub_reg == 3'd0)
                begin
                    sub_next = 3'd1;
                end
                else
                begin
                    if (ent_hit)
                    begin
                        hit_next = !list_reg[1];
                    end
                    idx_next = idx_reg + IW'(1);
                    state_next = S_SCAN;
                end
            end
            S_WRITE:
            begin
                if (found_reg)
                begin
                    res_next.status = ST_MERGED;
                    if (!is_rect)
                    begin
                        c_we[list_reg[1]] = 1'b1;
                    end
                end
                else if (int'(cnt_sel) >= (is_rect ? MAX_RECTS : MAX_CIRCLES))
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    if (is_rect)
                    begin
                        r_we[list_reg[1]] = 1'b1;
                    end
                    else
                    begin
                        c_we[list_reg[1]] = 1'b1;
                    end
                    inc_en = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                rv_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        fidx_reg <= fidx_next;
        res_reg <= res_next;
        sub_reg <= sub_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg <= 1'b0;
            list_reg <= '0;
            hit_reg <= 1'b0;
            found_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            rv_reg <= rv_next;
            list_reg <= list_next;
            hit_reg <= hit_next;
            found_reg <= found_next;
            if (inc_en)
            begin
                cnt_reg[cnt_inc] <= cnt_reg[cnt_inc] + IW'(1);
            end
        end
    end

    assign res_valid = rv_reg;
    assign res = res_reg;
endmodule

/* hw/rtl/shape_region_hit_test_core.sv */
// Operation: an add scans one list and a query scans up to four lists, one stored entry at a time
// in the back end; per entry an add passes SCAN and CALC, and a query passes SCAN, CALC and TEST,
// where TEST holds the registered multiply stage.
// Throughput: one request at a time in the back end; a two-entry queue in front absorbs input.
// Reset: rst_n asynchronous active low clears list counts, queue and result valid; stores
// keep contents and are read only below their count.
module shape_region_hit_test_core #(
    parameter int MAX_CIRCLES = srht_pkg::MAX_CIRCLES_DEF,
    parameter int MAX_RECTS = srht_pkg::MAX_RECTS_DEF,
    parameter int TRIG_FRAC_BITS = srht_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: operation[1:0], excluded[2], point_x[17:3], point_y[32:18],
    //        size_a[46:33], size_b[60:47], rotation_deg[69:61], zero pad to 72
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: inside_res[0], status[2:1], zero pad to 8
    output logic [7:0]  m_tdata
);
    import srht_pkg::*;

    cmd_t in_cmd;
    cmd_t q_cmd;
    logic q_valid;
    logic q_ready;
    res_t res;

    // unpack request
    assign in_cmd.op = op_t'(s_tdata[1:0]);
    assign in_cmd.excluded = s_tdata[2];
    assign in_cmd.x = s_tdata[17:3];
    assign in_cmd.y = s_tdata[32:18];
    assign in_cmd.a = s_tdata[46:33];
    assign in_cmd.b = s_tdata[60:47];
    assign in_cmd.rot = s_tdata[69:61];
    assign in_cmd.zero = 1'b0;

    // front: classify and queue
    srht_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(in_cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd));

    // back: scan lists, test, update stores
    srht_back #(
        .MAX_CIRCLES(MAX_CIRCLES), .MAX_RECTS(MAX_RECTS),
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(res));

    assign m_tdata = {5'b0, res.status, res.in_area};
endmodule

/* hw/rtl/srht_checker.sv */
module srht_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:3] == 5'b0)
        else $error("pad bits set");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[2:1] == 2'b0)
        else $error("query with status");
    a_rst: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("valid after reset");
endmodule

bind shape_region_hit_test_core srht_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));

/* tb/sv/shape_region_hit_test_checker.sv */
`timescale 1ns / 1ps

module shape_region_hit_test_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    output int          fail_count,
    output int          pending_count
);
    import srht_pkg::*;

    localparam int DEPTH = 16;

    typedef struct {
        longint cx;
        longint cy;
        longint r2;
    } circ_t;

    typedef struct {
        longint rx;
        longint ry;
        longint w;
        longint h;
        int     rot;
    } rect_t;

    typedef struct {
        logic    in_area;
        status_t status;
    } verdict_t;

    circ_t    circ_tbl [2][DEPTH];
    rect_t    rect_tbl [2][DEPTH];
    int       circ_cnt [2];
    int       rect_cnt [2];
    longint   sin_q14 [0:90];
    verdict_t verdicts [$];

    initial
    begin
        for (int d = 0; d <= 90; d++)
            sin_q14[d] = longint'($floor($sin(3.14159265358979323846 * d / 180.0)
                                      * 16384.0 + 0.5));
    end

    assign pending_count = verdicts.size();

    function automatic longint sin_of(int deg);
        int d;
        d = deg % 360;
        if (d <= 90)  return sin_q14[d];
        if (d <= 180) return sin_q14[180 - d];
        if (d <= 270) return -sin_q14[d - 180];
        return -sin_q14[360 - d];
    endfunction

    // floor((v + half) / one), i.e. round half up
    function automatic longint round_half_up(longint v);
        return (v + 64'sd8192) >>> 14;
    endfunction

    function automatic bit circle_holds(circ_t c, longint px, longint py);
        longint dx;
        longint dy;
        dx = px - c.cx;
        dy = py - c.cy;
        return dx * dx + dy * dy <= c.r2;
    endfunction

    function automatic bit rect_holds(rect_t r, longint px, longint py);
        longint dx;
        longint dy;
        longint s;
        longint c;
        longint xr;
        longint yr;
        dx = px - r.rx;
        dy = py - r.ry;
        if (r.rot > 0)
        begin
            s = sin_of(r.rot);
            c = sin_of(r.rot + 90);
            xr = round_half_up(dx * c + dy * s);
            yr = round_half_up(dy * c - dx * s);
            dx = xr;
            dy = yr;
        end
        return dx >= 0 && dx < r.w && dy >= 0 && dy < r.h;
    endfunction

    function automatic verdict_t area_request(logic [71:0] d);
        verdict_t v;
        op_t      op;
        int       ex;
        longint   px;
        longint   py;
        longint   a;
        longint   b;
        int       rot;
        bit       hit;
        bit       found;
        op  = op_t'(d[1:0]);
        ex  = d[2];
        px  = longint'($signed(d[17:3]));
        py  = longint'($signed(d[32:18]));
        a   = d[46:33];
        b   = d[60:47];
        rot = int'(d[69:61]) % 360;
        v.in_area = 1'b0;
        v.status = ST_ADDED;
        found = 1'b0;
        case (op)
            OP_QUERY:
            begin
                hit = 1'b0;
                for (int i = 0; i < circ_cnt[0]; i++) hit |= circle_holds(circ_tbl[0][i], px, py);
                for (int i = 0; i < rect_cnt[0]; i++) hit |= rect_holds(rect_tbl[0][i], px, py);
                for (int i = 0; i < circ_cnt[1]; i++)
                    if (circle_holds(circ_tbl[1][i], px, py)) hit = 1'b0;
                for (int i = 0; i < rect_cnt[1]; i++)
                    if (rect_holds(rect_tbl[1][i], px, py)) hit = 1'b0;
                v.in_area = hit;
            end
            OP_ADD_CIRCLE:
            begin
                if (a == 0)
                    v.status = ST_ZERO;
                else
                begin
                    for (int i = 0; i < circ_cnt[ex] && !found; i++)
                        if (circ_tbl[ex][i].cx == px && circ_tbl[ex][i].cy == py)
                        begin
                            if (circ_tbl[ex][i].r2 < a * a) circ_tbl[ex][i].r2 = a * a;
                            found = 1'b1;
                        end
                    if (found)
                        v.status = ST_MERGED;
                    else if (circ_cnt[ex] >= DEPTH)
                        v.status = ST_FULL;
                    else
                    begin
                        circ_tbl[ex][circ_cnt[ex]] = '{px, py, a * a};
                        circ_cnt[ex]++;
                    end
                end
            end
            OP_ADD_RECT:
            begin
                if (a == 0 || b == 0)
                    v.status = ST_ZERO;
                else
                begin
                    for (int i = 0; i < rect_cnt[ex]; i++)
                        if (rect_tbl[ex][i].rx == px && rect_tbl[ex][i].ry == py &&
                            rect_tbl[ex][i].w == a && rect_tbl[ex][i].h == b &&
                            rect_tbl[ex][i].rot == rot)
                            found = 1'b1;
                    if (found)
                        v.status = ST_MERGED;
                    else if (rect_cnt[ex] >= DEPTH)
                        v.status = ST_FULL;
                    else
                    begin
                        rect_tbl[ex][rect_cnt[ex]] = '{px, py, a, b, rot};
                        rect_cnt[ex]++;
                    end
                end
            end
            default: ;  // unused code: no effect
        endcase
        return v;
    endfunction

    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (verdicts.size() == 0)
                begin
                    $error("result with no request outstanding: %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_v = verdicts.pop_front();
                    if (m_tdata[0] !== exp_v.in_area)
                    begin
                        $error("inside_res: expected %0d, got %0d", exp_v.in_area, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[2:1] !== exp_v.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_v.status, m_tdata[2:1]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                verdicts.push_back(area_request(s_tdata));
        end
    end

endmodule

/* tb/sv/shape_region_hit_test_core_test.sv */
`timescale 1ns / 1ps

module shape_region_hit_test_core_test;
    import srht_pkg::*;

    localparam int RANDOM_REQS = 750;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // op[1:0] excluded[2] x[17:3] y[32:18] a[46:33] b[60:47] rot[69:61]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // inside_res[0] status[2:1]
    int          fail_count;
    int          pending_count;
    int          sent_count;
    bit          hold_rx;

    shape_region_hit_test_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    shape_region_hit_test_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [71:0] pack_req(op_t op, bit ex, int x, int y, int a, int b,
                                             int rot);
        logic [71:0] d;
        d = '0;
        d[1:0]   = op;
        d[2]     = ex;
        d[17:3]  = x[14:0];
        d[32:18] = y[14:0];
        d[46:33] = a[13:0];
        d[60:47] = b[13:0];
        d[69:61] = rot[8:0];
        return d;
    endfunction

    // hand one request over; tvalid stays high into the next one
    task automatic send_req(logic [71:0] d);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_count++;
    endtask

    task automatic idle_gap(int n);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // coordinates mostly near the origin so shapes overlap and queries hit
    function automatic int pick_coord();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 400) - 200;
        return $urandom_range(0, 32767) - 16384;
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r < 17) return $urandom_range(1, 150);
        return $urandom_range(1, 16383);
    endfunction

    // receiver: random stall pattern, with calm stretches, plus one long hold
    always @(posedge clk)
    begin
        if (!rst_n || hold_rx)
            m_tready <= 1'b0;
        else if ((sent_count / 100) % 2 == 1)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        hold_rx = 1'b0;
        wait (sent_count >= 300);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_rx <= 1'b0;
    end

    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [71:0] seen [$];
        logic [71:0] d;
        int          burst;
        int          r;
        op_t         op;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        sent_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: merges, duplicates, zero sizes, rotation wrap, unused code, extremes
        send_req(pack_req(OP_ADD_CIRCLE, 0, 0, 0, 10, 0, 0));
        send_req(pack_req(OP_ADD_CIRCLE, 0, 0, 0, 20, 0, 0));
        send_req(pack_req(OP_ADD_CIRCLE, 0, 0, 0, 5, 0, 0));
        send_req(pack_req(OP_ADD_CIRCLE, 1, 3, 3, 0, 0, 0));
        send_req(pack_req(OP_ADD_RECT, 0, -5, -5, 10, 10, 0));
        send_req(pack_req(OP_ADD_RECT, 0, 40, 40, 30, 12, 45));
        send_req(pack_req(OP_ADD_RECT, 0, 40, 40, 30, 12, 405));
        send_req(pack_req(OP_ADD_RECT, 0, 1, 1, 5, 0, 0));
        send_req(pack_req(OP_ADD_RECT, 0, 1, 1, 0, 5, 0));
        send_req(pack_req(OP_ADD_CIRCLE, 1, 3, 3, 2, 0, 0));
        send_req(pack_req(OP_ADD_RECT, 1, -3, 0, 4, 4, 90));
        send_req(pack_req(OP_ADD_RECT, 0, -16384, -16384, 16383, 16383, 359));
        send_req(pack_req(OP_ADD_RECT, 1, 16383, 16383, 16383, 16383, 511));
        send_req(pack_req(OP_ADD_CIRCLE, 0, 16383, -16384, 16383, 0, 0));
        send_req(pack_req(OP_NONE, 1, 0, 0, 16383, 16383, 511));
        send_req(pack_req(OP_QUERY, 0, 0, 0, 0, 0, 0));
        send_req(pack_req(OP_QUERY, 1, 3, 3, 16383, 16383, 511));
        send_req(pack_req(OP_QUERY, 0, 20, 0, 0, 0, 0));
        send_req(pack_req(OP_QUERY, 0, 45, 50, 0, 0, 0));
        send_req(pack_req(OP_QUERY, 0, -2, 2, 0, 0, 0));
        send_req(pack_req(OP_QUERY, 0, -16384, -16384, 0, 0, 0));
        send_req(pack_req(OP_QUERY, 0, 16383, 16383, 0, 0, 0));
        send_req(pack_req(OP_QUERY, 0, 16383, -16384, 0, 0, 0));
        idle_gap(3);

        // random: bursts of requests with gaps, mostly queries against filled lists
        burst = $urandom_range(1, 12);
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                op = OP_QUERY;
            else if (r < 75)
                op = OP_ADD_CIRCLE;
            else if (r < 95)
                op = OP_ADD_RECT;
            else
                op = OP_NONE;
            if (op != OP_QUERY && seen.size() > 0 && $urandom_range(0, 4) == 0)
                d = seen[$urandom_range(0, seen.size() - 1)];  // repeat an earlier non-query request
            else
                d = pack_req(op, $urandom_range(0, 1), pick_coord(), pick_coord(),
                             pick_size(), pick_size(), $urandom_range(0, 511));
            if (op != OP_QUERY && seen.size() < 64)
                seen.push_back(d);
            send_req(d);
            if (--burst == 0)
            begin
                idle_gap($urandom_range(1, 20));
                burst = $urandom_range(1, 12);
            end
        end
        s_tvalid <= 1'b0;

        wait (pending_count == 0);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/srht_pkg.sv
hw/rtl/srht_ram.sv
hw/rtl/srht_front.sv
hw/rtl/srht_back.sv
hw/rtl/shape_region_hit_test_core.sv
hw/rtl/srht_checker.sv
tb/sv/shape_region_hit_test_checker.sv
tb/sv/shape_region_hit_test_core_test.sv
